[hw/rtl/tbbp_pkg.sv]
// Shared types, codes and helpers for the tagged big-integer byte parser.
// No dependencies; engine, top level and checker use scoped names, test files import it.
package tbbp_pkg;

  // Header byte fields.
  localparam logic [7:0] HDR_SIGN_MASK = 8'h03;
  localparam logic [7:0] HDR_LEN_MASK  = 8'h0c;
  localparam logic [7:0] HDR_RSVD_MASK = 8'hf0;
  localparam int         HDR_LEN_LSB   = 2;

  // First byte of a rational buffer.
  localparam logic [7:0] RATIONAL_PREFIX = 8'h10;

  // Sign codes as they appear in a header.
  localparam logic [1:0] HS_ZERO = 2'd0;
  localparam logic [1:0] HS_BAD  = 2'd2;
  localparam logic [1:0] HS_NEG  = 2'd3;

  // Sign codes as reported for a completed number.
  localparam logic [1:0] SIGN_NONE = 2'd0;
  localparam logic [1:0] SIGN_POS  = 2'd1;
  localparam logic [1:0] SIGN_NEG  = 2'd2;

  // Container modes.
  localparam logic [1:0] MODE_UNSIGNED = 2'd0;

  // Register map.
  localparam logic REG_CONTAINER_MODE = 1'b0;

  // Error codes.
  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_RESERVED   = 4'd1;
  localparam logic [3:0] ERR_SIGN_CODE  = 4'd2;
  localparam logic [3:0] ERR_ZERO_LEN   = 4'd3;
  localparam logic [3:0] ERR_TRUNCATED  = 4'd4;
  localparam logic [3:0] ERR_TRAILING   = 4'd5;
  localparam logic [3:0] ERR_PREFIX     = 4'd6;
  localparam logic [3:0] ERR_DENOM      = 4'd7;
  localparam logic [3:0] ERR_NEG_UNSIGN = 4'd8;
  localparam logic [3:0] ERR_LEN_OVF    = 4'd9;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [31:0] payload_index;
    logic        number_slot;
    logic        number_done;
    logic [1:0]  sign_code;
    logic [34:0] mag_bits;
    logic        buffer_accepted;
    logic [3:0]  error_code;
  } result_t;

  // Number of significant bits in a byte.
  function automatic logic [3:0] bit_len8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        n = 4'(k + 1);
      end
    end
    return n;
  endfunction

endpackage

[hw/rtl/tbbp_byte_if.sv]
// Byte channel into the parser: one buffer byte and its last-byte flag per beat.
// No dependencies.
interface tbbp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_final;

  modport source (output valid, output data_byte, output is_final, input ready);
  modport sink (input valid, input data_byte, input is_final, output ready);
endinterface

[hw/rtl/tbbp_result_if.sv]
// Result channel out of the parser: one result per accepted byte.
// No dependencies.
interface tbbp_result_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [31:0] payload_index;
  logic        number_slot;
  logic        number_done;
  logic [1:0]  sign_code;
  logic [34:0] mag_bits;
  logic        buffer_accepted;
  logic [3:0]  error_code;

  modport source (output valid, output payload_valid, output payload_byte,
                  output payload_index, output number_slot, output number_done,
                  output sign_code, output mag_bits, output buffer_accepted,
                  output error_code, input ready);
  modport sink (input valid, input payload_valid, input payload_byte,
                input payload_index, input number_slot, input number_done,
                input sign_code, input mag_bits, input buffer_accepted,
                input error_code, output ready);
endinterface

[hw/rtl/tbbp_engine.sv]
// Parse state and combinational next-state logic for one buffer byte.
// Depends on tbbp_pkg for codes, the result struct and bit_len8.
module tbbp_engine #(
  parameter int LENGTH_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              is_final,
  input  logic [1:0]        container_mode,
  output tbbp_pkg::result_t result
);

  localparam int TBW = LENGTH_WIDTH + 3;

  typedef enum logic [2:0] {
    PH_START,
    PH_HEADER,
    PH_LENGTH,
    PH_MAG,
    PH_DONE,
    PH_ERROR
  } phase_t;

  phase_t                  phase, phase_next;
  logic [3:0]              len_field_bytes, len_field_bytes_next;
  logic [3:0]              len_cnt, len_cnt_next;
  logic [LENGTH_WIDTH-1:0] len_acc, len_acc_next;
  logic [LENGTH_WIDTH-1:0] remaining, remaining_next;
  logic [LENGTH_WIDTH-1:0] position, position_next;
  logic [TBW-1:0]          top_bits, top_bits_next;
  logic [1:0]              header_sign, header_sign_next;
  logic                    slot, slot_next;
  logic [3:0]              sticky_error, sticky_error_next;

  // Bits a length byte may carry at each position without exceeding LENGTH_WIDTH.
  logic [7:0] allow_mask [8];

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      if (8 * k >= LENGTH_WIDTH) begin
        allow_mask[k] = '0;
      end else if (LENGTH_WIDTH - 8 * k >= 8) begin
        allow_mask[k] = 8'hff;
      end else begin
        allow_mask[k] = 8'hff >> (8 - (LENGTH_WIDTH - 8 * k));
      end
    end
  end

  always_comb begin
    logic                    raise_en;
    logic [3:0]              raise_code;
    logic                    do_complete;
    logic [1:0]              sign;
    logic [LENGTH_WIDTH-1:0] acc_upd;
    logic [LENGTH_WIDTH-1:0] rem_dec;
    logic [3:0]              cnt_inc;
    logic [1:0]              hdr_len_code;
    logic                    hdr_rsvd;

    phase_next           = phase;
    len_field_bytes_next = len_field_bytes;
    len_cnt_next         = len_cnt;
    len_acc_next         = len_acc;
    remaining_next       = remaining;
    position_next        = position;
    top_bits_next        = top_bits;
    header_sign_next     = header_sign;
    slot_next            = slot;
    sticky_error_next    = sticky_error;
    result               = '0;
    raise_en             = 1'b0;
    raise_code           = tbbp_pkg::ERR_NONE;
    do_complete          = 1'b0;
    sign                 = tbbp_pkg::SIGN_NONE;

    acc_upd      = len_acc | (LENGTH_WIDTH'(data_byte) << {len_cnt[2:0], 3'b000});
    rem_dec      = remaining - 1'b1;
    cnt_inc      = len_cnt + 4'd1;
    hdr_len_code = 2'((data_byte & tbbp_pkg::HDR_LEN_MASK) >> tbbp_pkg::HDR_LEN_LSB);
    hdr_rsvd     = |(data_byte & tbbp_pkg::HDR_RSVD_MASK);

    case (phase)
      PH_START, PH_HEADER: begin
        if (phase == PH_START && container_mode[1]) begin
          if (data_byte != tbbp_pkg::RATIONAL_PREFIX) begin
            raise_en   = 1'b1;
            raise_code = tbbp_pkg::ERR_PREFIX;
          end else begin
            phase_next = PH_HEADER;
          end
        end else if (hdr_rsvd) begin
          raise_en   = 1'b1;
          raise_code = tbbp_pkg::ERR_RESERVED;
        end else if ((data_byte & tbbp_pkg::HDR_SIGN_MASK) == 8'(tbbp_pkg::HS_BAD)) begin
          raise_en   = 1'b1;
          raise_code = tbbp_pkg::ERR_SIGN_CODE;
        end else begin
          header_sign_next     = 2'(data_byte & tbbp_pkg::HDR_SIGN_MASK);
          len_field_bytes_next = 4'd1 << hdr_len_code;
          len_cnt_next         = '0;
          len_acc_next         = '0;
          phase_next           = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (|(data_byte & ~allow_mask[len_cnt[2:0]])) begin
          raise_en   = 1'b1;
          raise_code = tbbp_pkg::ERR_LEN_OVF;
        end else begin
          len_acc_next = acc_upd;
          len_cnt_next = cnt_inc;
          if (cnt_inc >= len_field_bytes) begin
            if (header_sign == tbbp_pkg::HS_ZERO && acc_upd != '0) begin
              raise_en   = 1'b1;
              raise_code = tbbp_pkg::ERR_ZERO_LEN;
            end else if (acc_upd == '0) begin
              top_bits_next = '0;
              do_complete   = 1'b1;
            end else begin
              remaining_next = acc_upd;
              position_next  = '0;
              top_bits_next  = '0;
              phase_next     = PH_MAG;
            end
          end
        end
      end
      PH_MAG: begin
        result.payload_valid = 1'b1;
        result.payload_byte  = data_byte;
        result.payload_index = 32'(position);
        result.number_slot   = slot;
        if (data_byte != 8'd0) begin
          top_bits_next = {position, 3'b000} + TBW'(tbbp_pkg::bit_len8(data_byte));
        end
        position_next  = position + 1'b1;
        remaining_next = rem_dec;
        if (rem_dec == '0) begin
          do_complete = 1'b1;
        end
      end
      PH_DONE: begin
        raise_en   = 1'b1;
        raise_code = tbbp_pkg::ERR_TRAILING;
      end
      default: begin
      end
    endcase

    if (do_complete) begin
      if (top_bits_next != '0) begin
        sign = (header_sign == tbbp_pkg::HS_NEG) ? tbbp_pkg::SIGN_NEG : tbbp_pkg::SIGN_POS;
      end
      result.number_slot = slot;
      result.number_done = 1'b1;
      result.sign_code   = sign;
      result.mag_bits    = 35'(top_bits_next);
      if (slot && sign != tbbp_pkg::SIGN_POS) begin
        raise_en   = 1'b1;
        raise_code = tbbp_pkg::ERR_DENOM;
      end else if (!slot && container_mode == tbbp_pkg::MODE_UNSIGNED &&
                   sign == tbbp_pkg::SIGN_NEG) begin
        raise_en   = 1'b1;
        raise_code = tbbp_pkg::ERR_NEG_UNSIGN;
      end else if (container_mode[1] && !slot) begin
        slot_next  = 1'b1;
        phase_next = PH_HEADER;
      end else begin
        phase_next = PH_DONE;
      end
    end

    if (raise_en) begin
      if (sticky_error == tbbp_pkg::ERR_NONE) begin
        sticky_error_next = raise_code;
      end
      phase_next = PH_ERROR;
    end

    if (is_final) begin
      if (sticky_error_next == tbbp_pkg::ERR_NONE && phase_next != PH_DONE) begin
        sticky_error_next = tbbp_pkg::ERR_TRUNCATED;
      end
      result.buffer_accepted = (sticky_error_next == tbbp_pkg::ERR_NONE);
      result.error_code      = sticky_error_next;
      // The last byte of a buffer always returns the parser to its initial state.
      phase_next           = PH_START;
      len_field_bytes_next = '0;
      len_cnt_next         = '0;
      len_acc_next         = '0;
      remaining_next       = '0;
      position_next        = '0;
      top_bits_next        = '0;
      header_sign_next     = '0;
      slot_next            = 1'b0;
      sticky_error_next    = tbbp_pkg::ERR_NONE;
    end else begin
      result.error_code = sticky_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_START;
      len_field_bytes <= '0;
      len_cnt         <= '0;
      len_acc         <= '0;
      remaining       <= '0;
      position        <= '0;
      top_bits        <= '0;
      header_sign     <= '0;
      slot            <= 1'b0;
      sticky_error    <= tbbp_pkg::ERR_NONE;
    end else if (step) begin
      phase           <= phase_next;
      len_field_bytes <= len_field_bytes_next;
      len_cnt         <= len_cnt_next;
      len_acc         <= len_acc_next;
      remaining       <= remaining_next;
      position        <= position_next;
      top_bits        <= top_bits_next;
      header_sign     <= header_sign_next;
      slot            <= slot_next;
      sticky_error    <= sticky_error_next;
    end
  end

endmodule

[hw/rtl/tagged_bigint_byte_parser.sv]
// Top level of the tagged big-integer byte parser: input register, parse engine,
// result register and the APB mode register. Depends on tbbp_pkg, both channel
// interfaces and tbbp_engine.
//
//   channel   | kind      | beat carries
//   ----------+-----------+------------------------------------------------------
//   bytes     | sink      | data_byte, is_final
//   results   | source    | payload, number completion, acceptance, error code
//   apb       | APB slave | container_mode at byte address 0
//
// Each byte passes through the input register, then through the parse logic into the
// result register. One byte is accepted every cycle while the results are not stalled;
// the parse state update for one byte feeds the next.
// A stalled result register holds its beat and back-pressures the input register.
// Reset is synchronous and returns the parser to expect a prefix or header, mode unsigned.
module tagged_bigint_byte_parser #(
  parameter int LENGTH_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  tbbp_byte_if.sink            bytes,
  tbbp_result_if.source        results
);

  logic [1:0]        container_mode;
  logic              in_valid;
  logic [7:0]        in_byte;
  logic              in_final;
  logic              out_valid;
  tbbp_pkg::result_t out_res;
  tbbp_pkg::result_t step_res;
  logic              step;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == tbbp_pkg::REG_CONTAINER_MODE) ? {30'd0, container_mode} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      container_mode <= tbbp_pkg::MODE_UNSIGNED;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == tbbp_pkg::REG_CONTAINER_MODE) begin
      container_mode <= pwdata[1:0];
    end
  end

  // The input register moves on whenever the result register is empty or being drained.
  assign step        = in_valid && (!out_valid || results.ready);
  assign bytes.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (bytes.ready) begin
      in_valid <= bytes.valid;
    end
    if (bytes.valid && bytes.ready) begin
      in_byte  <= bytes.data_byte;
      in_final <= bytes.is_final;
    end
  end

  tbbp_engine #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .data_byte     (in_byte),
    .is_final      (in_final),
    .container_mode(container_mode),
    .result        (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
    if (step) begin
      out_res <= step_res;
    end
  end

  assign results.valid           = out_valid;
  assign results.payload_valid   = out_res.payload_valid;
  assign results.payload_byte    = out_res.payload_byte;
  assign results.payload_index   = out_res.payload_index;
  assign results.number_slot     = out_res.number_slot;
  assign results.number_done     = out_res.number_done;
  assign results.sign_code       = out_res.sign_code;
  assign results.mag_bits        = out_res.mag_bits;
  assign results.buffer_accepted = out_res.buffer_accepted;
  assign results.error_code      = out_res.error_code;

endmodule

[hw/rtl/tbbp_checker.sv]
// Port-level assertions for the parser, bound to the top level.
// Depends on tbbp_pkg and tagged_bigint_byte_parser.
module tbbp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        payload_valid,
  input logic [7:0]  payload_byte,
  input logic [31:0] payload_index,
  input logic        number_done,
  input logic [1:0]  sign_code,
  input logic [34:0] mag_bits,
  input logic        buffer_accepted,
  input logic [3:0]  error_code
);

  // An accepted buffer never carries an error.
  a_accept_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && buffer_accepted |-> error_code == tbbp_pkg::ERR_NONE)
    else $error("buffer accepted with an error code");

  // Payload fields are zero on beats that are not magnitude bytes.
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !payload_valid |-> payload_byte == 8'd0 && payload_index == 32'd0)
    else $error("payload fields set on a non-magnitude beat");

  // Number fields are zero unless the beat completes a number.
  a_number_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !number_done |-> sign_code == tbbp_pkg::SIGN_NONE && mag_bits == 35'd0)
    else $error("number fields set without number_done");

  // A stalled result beat holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(error_code) && $stable(payload_byte))
    else $error("result beat changed while stalled");

endmodule

bind tagged_bigint_byte_parser tbbp_checker u_tbbp_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .payload_valid  (results.payload_valid),
  .payload_byte   (results.payload_byte),
  .payload_index  (results.payload_index),
  .number_done    (results.number_done),
  .sign_code      (results.sign_code),
  .mag_bits       (results.mag_bits),
  .buffer_accepted(results.buffer_accepted),
  .error_code     (results.error_code)
);

[test/tbbp_parse_checker.sv]
// Checker for the tagged big-integer byte parser: follows the mode register on the APB port,
// predicts one result per accepted byte and compares result beats in order.
// Depends on tbbp_pkg and the two channel interfaces.
`timescale 1ns / 1ps

module tbbp_parse_checker #(
  parameter int LENGTH_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  tbbp_byte_if        bytes,
  tbbp_result_if      results,
  output int          mismatches,
  output int          expected_left
);
  import tbbp_pkg::*;

  localparam logic [2:0] MODE_ADDR = 3'(4 * REG_CONTAINER_MODE);

  typedef enum logic [2:0] {
    PH_START, PH_HEADER, PH_LENGTH, PH_MAG, PH_DONE, PH_ERROR
  } phase_t;

  phase_t      phase;
  logic [1:0]  mode;
  logic [3:0]  len_bytes;
  logic [3:0]  len_count;
  logic [63:0] len_acc;
  logic [63:0] remaining;
  logic [63:0] position;
  logic [63:0] top_bits;
  logic [1:0]  hdr_sign;
  logic        slot;
  logic [3:0]  first_error;

  result_t     pending[$];

  function automatic void restart_parse();
    phase       = PH_START;
    len_bytes   = '0;
    len_count   = '0;
    len_acc     = '0;
    remaining   = '0;
    position    = '0;
    top_bits    = '0;
    hdr_sign    = HS_ZERO;
    slot        = 1'b0;
    first_error = ERR_NONE;
  endfunction

  function automatic void flag_error(input logic [3:0] code);
    if (first_error == ERR_NONE) begin
      first_error = code;
    end
    phase = PH_ERROR;
  endfunction

  function automatic void take_header(input logic [7:0] b);
    if ((b & HDR_RSVD_MASK) != 0) begin
      flag_error(ERR_RESERVED);
    end else if ((b & HDR_SIGN_MASK) == HS_BAD) begin
      flag_error(ERR_SIGN_CODE);
    end else begin
      hdr_sign  = b[1:0];
      len_bytes = 4'd1 << ((b & HDR_LEN_MASK) >> HDR_LEN_LSB);
      len_count = '0;
      len_acc   = '0;
      phase     = PH_LENGTH;
    end
  endfunction

  // Length bytes may only carry bits below LENGTH_WIDTH.
  function automatic bit length_too_wide(input int idx, input logic [7:0] b);
    int lo;
    int room;
    lo = 8 * idx;
    if (lo >= LENGTH_WIDTH) begin
      return b != 0;
    end
    room = LENGTH_WIDTH - lo;
    if (room >= 8) begin
      return 1'b0;
    end
    return (b >> room) != 0;
  endfunction

  function automatic void finish_number(inout result_t r);
    logic [1:0] s;
    s = SIGN_NONE;
    if (top_bits != 0) begin
      s = (hdr_sign == HS_NEG) ? SIGN_NEG : SIGN_POS;
    end
    r.number_slot = slot;
    r.number_done = 1'b1;
    r.sign_code   = s;
    r.mag_bits    = top_bits[34:0];
    if (slot && s != SIGN_POS) begin
      flag_error(ERR_DENOM);
    end else if (!slot && mode == MODE_UNSIGNED && s == SIGN_NEG) begin
      flag_error(ERR_NEG_UNSIGN);
    end else if (mode[1] && !slot) begin
      // Rational modes go on to the denominator.
      slot  = 1'b1;
      phase = PH_HEADER;
    end else begin
      phase = PH_DONE;
    end
  endfunction

  function automatic result_t parse_byte(input logic [7:0] b, input logic fin);
    result_t r;
    int      msb;
    r = '0;
    case (phase)
      PH_START: begin
        if (mode[1]) begin
          if (b != RATIONAL_PREFIX) begin
            flag_error(ERR_PREFIX);
          end else begin
            phase = PH_HEADER;
          end
        end else begin
          take_header(b);
        end
      end
      PH_HEADER: begin
        take_header(b);
      end
      PH_LENGTH: begin
        if (length_too_wide(int'(len_count), b)) begin
          flag_error(ERR_LEN_OVF);
        end else begin
          len_acc   = len_acc | (64'(b) << (8 * (len_count & 4'd7)));
          len_count = len_count + 4'd1;
          if (len_count >= len_bytes) begin
            if (hdr_sign == HS_ZERO && len_acc != 0) begin
              flag_error(ERR_ZERO_LEN);
            end else if (len_acc == 0) begin
              top_bits = '0;
              finish_number(r);
            end else begin
              remaining = len_acc;
              position  = '0;
              top_bits  = '0;
              phase     = PH_MAG;
            end
          end
        end
      end
      PH_MAG: begin
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        r.payload_index = position[31:0];
        r.number_slot   = slot;
        msb = 0;
        for (int k = 7; k >= 0; k--) begin
          if (b[k] && msb == 0) begin
            msb = k + 1;
          end
        end
        // Zero bytes leave the bit count where the last nonzero byte put it.
        if (b != 0) begin
          top_bits = 8 * position + 64'(msb);
        end
        position  = position + 1;
        remaining = remaining - 1;
        if (remaining == 0) begin
          finish_number(r);
        end
      end
      PH_DONE: begin
        flag_error(ERR_TRAILING);
      end
      default: begin
      end
    endcase
    if (fin) begin
      if (first_error == ERR_NONE && phase != PH_DONE) begin
        first_error = ERR_TRUNCATED;
      end
      r.buffer_accepted = (first_error == ERR_NONE);
      r.error_code      = first_error;
      restart_parse();
    end else begin
      r.error_code = first_error;
    end
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      mode = MODE_UNSIGNED;
      restart_parse();
      pending.delete();
      mismatches = 0;
    end else begin
      // A result beat always belongs to an earlier byte, so compare before predicting.
      if (results.valid && results.ready) begin
        if (pending.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing expected, error_code %0h", $time,
                   results.error_code);
        end else begin
          want = pending.pop_front();
          compare_field("payload_valid", want.payload_valid, results.payload_valid);
          compare_field("payload_byte", want.payload_byte, results.payload_byte);
          compare_field("payload_index", want.payload_index, results.payload_index);
          compare_field("number_slot", want.number_slot, results.number_slot);
          compare_field("number_done", want.number_done, results.number_done);
          compare_field("sign_code", want.sign_code, results.sign_code);
          compare_field("mag_bits", want.mag_bits, results.mag_bits);
          compare_field("buffer_accepted", want.buffer_accepted, results.buffer_accepted);
          compare_field("error_code", want.error_code, results.error_code);
        end
      end
      if (bytes.valid && bytes.ready) begin
        pending.push_back(parse_byte(bytes.data_byte, bytes.is_final));
      end
      if (psel && penable && pwrite && pready && paddr == MODE_ADDR) begin
        mode = pwdata[1:0];
      end
    end
    expected_left = pending.size();
  end

endmodule

[test/tb.sv]
// Testbench top for the tagged big-integer byte parser: clock, reset, APB mode writes,
// byte buffers with random gaps and result stalls, watchdog and verdict.
// Depends on tbbp_pkg, both channel interfaces, the parser and tbbp_parse_checker.
`timescale 1ns / 1ps

module tb;
  import tbbp_pkg::*;

  localparam int         QUIET_LIMIT  = 500;
  localparam int         PIPE_CYCLES  = 4;
  localparam int         PHASE_BYTES  = 85;
  localparam logic [2:0] MODE_ADDR    = 3'(4 * REG_CONTAINER_MODE);

  localparam logic [1:0] MODE_SIGNED       = 2'd1;
  localparam logic [1:0] MODE_RATIONAL     = 2'd2;
  localparam logic [1:0] MODE_RATIONAL_ALT = 2'd3;
  localparam logic [1:0] HS_POS            = 2'd1;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          expected_left;
  int          quiet_cycles;
  int          phase_count;
  bit          steady;
  logic [1:0]  cur_mode;
  logic [7:0]  frame[$];

  tbbp_byte_if   bytes_ch ();
  tbbp_result_if results_ch ();

  tagged_bigint_byte_parser #(.LENGTH_WIDTH(32)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .bytes   (bytes_ch),
    .results (results_ch)
  );

  tbbp_parse_checker #(.LENGTH_WIDTH(32)) i_checker (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .bytes         (bytes_ch),
    .results       (results_ch),
    .mismatches    (mismatches),
    .expected_left (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (bytes_ch.valid && bytes_ch.ready) || (results_ch.valid && results_ch.ready)
        || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Result side: a fresh stall for every beat, none while steady is set.
  initial begin
    int stall;
    results_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        results_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      results_ch.ready <= 1'b1;
      do @(posedge clk); while (!results_ch.valid);
      @(negedge clk);
    end
  end

  // Entered and left at a falling edge; valid stays high for a back-to-back beat.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      bytes_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    bytes_ch.valid     <= 1'b1;
    bytes_ch.data_byte <= b;
    bytes_ch.is_final  <= fin;
    do @(posedge clk); while (!bytes_ch.ready);
    @(negedge clk);
  endtask

  task automatic hold_bytes_until_drained();
    bytes_ch.valid <= 1'b0;
    @(negedge clk);
    while (expected_left != 0) @(negedge clk);
  endtask

  task automatic send_frame(input int pause_at);
    for (int i = 0; i < frame.size(); i++) begin
      if (i == pause_at && i != 0) begin
        hold_bytes_until_drained();
      end
      send_byte(frame[i], i == frame.size() - 1);
    end
  endtask

  task automatic write_mode(input logic [1:0] value);
    hold_bytes_until_drained();
    repeat (PIPE_CYCLES) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_mode = value;
  endtask

  // One header, its length field and the magnitude bytes.
  task automatic add_number(input logic [1:0] sign, input int mag_len);
    logic [1:0] len_code;
    int         fill;
    len_code = 2'($urandom_range(0, 3));
    fill     = $urandom_range(0, 5);
    frame.push_back((8'(len_code) << HDR_LEN_LSB) | 8'(sign));
    for (int i = 0; i < (1 << len_code); i++) begin
      frame.push_back(8'(64'(mag_len) >> (8 * i)));
    end
    for (int i = 0; i < mag_len; i++) begin
      frame.push_back((fill == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
    end
    // Zero bytes on top must not count towards the bit length.
    if (mag_len > 1 && fill == 1) begin
      frame[frame.size() - 1] = 8'h00;
    end
  endtask

  function automatic int pick_length();
    if ($urandom_range(0, 11) == 0) begin
      return $urandom_range(7, 40);
    end
    return $urandom_range(0, 6);
  endfunction

  task automatic build_buffer();
    logic [1:0] sign;
    int         hdr;
    int         keep;
    int         n;
    frame.delete();
    if ($urandom_range(0, 19) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) frame.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (cur_mode[1]) begin
      frame.push_back(RATIONAL_PREFIX);
    end
    case ($urandom_range(0, 7))
      0:       sign = HS_ZERO;
      1, 2:    sign = HS_NEG;
      default: sign = HS_POS;
    endcase
    if (sign == HS_ZERO) begin
      add_number(sign, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
    end else begin
      add_number(sign, pick_length());
    end
    if (cur_mode[1]) begin
      case ($urandom_range(0, 9))
        0:       sign = HS_ZERO;
        1:       sign = HS_NEG;
        default: sign = HS_POS;
      endcase
      add_number(sign, (sign == HS_ZERO) ? 0 : pick_length());
    end
    hdr = cur_mode[1] ? 1 : 0;
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 5))
        0: frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom_range(0, 255));
        1: begin
          keep = (frame.size() > 1) ? $urandom_range(1, frame.size() - 1) : 1;
          while (frame.size() > keep) void'(frame.pop_back());
        end
        2: begin
          n = $urandom_range(1, 3);
          repeat (n) frame.push_back(8'($urandom_range(0, 255)));
        end
        3: frame[hdr] = frame[hdr] | (8'h01 << $urandom_range(4, 7));
        4: frame[hdr] = (frame[hdr] & ~HDR_SIGN_MASK) | 8'(HS_BAD);
        default: frame[hdr] = frame[hdr] | HDR_LEN_MASK;
      endcase
    end
  endtask

  initial begin
    logic [1:0] mode_plan[6];
    int         sent;
    mode_plan = '{MODE_SIGNED, MODE_RATIONAL, MODE_UNSIGNED, MODE_RATIONAL_ALT,
                  MODE_RATIONAL, MODE_SIGNED};
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    bytes_ch.valid     = 1'b0;
    bytes_ch.data_byte = '0;
    bytes_ch.is_final  = 1'b0;
    steady             = 1'b0;
    cur_mode           = MODE_UNSIGNED;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed buffers in unsigned mode straight after reset.
    frame = '{8'h00, 8'h00};                          // zero, empty magnitude
    send_frame(-1);
    frame = '{8'h01, 8'h01, 8'hff};                   // one full byte
    send_frame(-1);
    frame = '{8'h03, 8'h02, 8'h00, 8'h00};            // sign three, all-zero magnitude
    send_frame(-1);
    frame = '{8'hf1};                                 // reserved header bits
    send_frame(-1);
    frame = '{8'h02};                                 // sign code two
    send_frame(-1);
    frame = '{8'h00, 8'h01};                          // zero with a length
    send_frame(-1);
    frame = '{8'h0d, 8'h01, 8'h00, 8'h00, 8'h00, 8'h80};  // length beyond 32 bits
    send_frame(-1);
    frame = '{8'h03, 8'h01, 8'h80};                   // negative in unsigned mode
    send_frame(-1);
    frame = '{8'h01, 8'h01, 8'h05, 8'h07};            // trailing byte
    send_frame(-1);
    frame = '{8'h05, 8'h02};                          // cut off inside the length field
    send_frame(-1);

    for (phase_count = 0; phase_count < 6; phase_count++) begin
      write_mode(mode_plan[phase_count]);
      steady = (phase_count % 3 == 2);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_buffer();
        sent += frame.size();
        send_frame(($urandom_range(0, 7) == 0) ? $urandom_range(1, frame.size()) : -1);
      end
    end
    steady = 1'b0;

    hold_bytes_until_drained();
    repeat (PIPE_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_left == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/tbbp_pkg.sv
hw/rtl/tbbp_byte_if.sv
hw/rtl/tbbp_result_if.sv
hw/rtl/tbbp_engine.sv
hw/rtl/tagged_bigint_byte_parser.sv
hw/rtl/tbbp_checker.sv
test/tbbp_parse_checker.sv
test/tb.sv
